/* src/pwmcap_pkg.sv */
// Package for the PWM pulse capture to compare block.
// Widths, register indexes, sequencer states and multiply/divide unit types.
// No dependencies.
`default_nettype none
package pwmcap_pkg;

  localparam int CHANNELS = 3;
  localparam int CHAN_W   = 2;
  localparam int TIMER_W  = 16;
  localparam int REG_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int DUTY_W   = 7;

  localparam int MDU_W    = 32;
  localparam int MDU_B_W  = 16;
  localparam int STEP_W   = 6;

  localparam logic [STEP_W-1:0] MUL_STEPS  = STEP_W'(MDU_B_W);
  localparam logic [STEP_W-1:0] DIV_STEPS  = STEP_W'(MDU_W);
  localparam int               DUTY_DVD_W = 23;
  localparam logic [STEP_W-1:0] DUTY_STEPS = STEP_W'(DUTY_DVD_W);

  localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(100);

  localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_PERIOD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_COMPARE   = 2'd3;

  localparam logic [REG_W-1:0] MIN_PULSE_RST     = 16'd1000;
  localparam logic [REG_W-1:0] MAX_PULSE_RST     = 16'd2000;
  localparam logic [REG_W-1:0] OUTPUT_PERIOD_RST = 16'd1000;
  localparam logic [REG_W-1:0] MAX_COMPARE_RST   = 16'd1000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_DIV1,
    S_DIV2,
    S_EMIT
  } state_t;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } mdu_op_t;

  typedef struct packed {
    logic              start;
    mdu_op_t           op;
    logic [STEP_W-1:0] steps;
  } mdu_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mdu_sts_t;

endpackage
`default_nettype wire

/* src/pwmcap_in_if.sv */
// Capture channel: valid/ready handshake with one edge capture as payload.
// Depends on pwmcap_pkg.
`default_nettype none
interface pwmcap_in_if import pwmcap_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CHAN_W-1:0]   chan;
  logic                falling;
  logic [TIMER_W-1:0]  stamp;

  modport source (output valid, output chan, output falling, output stamp, input ready);
  modport sink (input valid, input chan, input falling, input stamp, output ready);
endinterface
`default_nettype wire

/* src/pwmcap_out_if.sv */
// Result channel: valid/ready handshake with one completed pulse as payload.
// Depends on pwmcap_pkg.
`default_nettype none
interface pwmcap_out_if import pwmcap_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CHAN_W-1:0]  out_chan;
  logic [TIMER_W-1:0] width;
  logic [REG_W-1:0]   compare;
  logic [DUTY_W-1:0]  duty_percent;

  modport source (output valid, output out_chan, output width, output compare,
                  output duty_percent, input ready);
  modport sink (input valid, input out_chan, input width, input compare,
                input duty_percent, output ready);
endinterface
`default_nettype wire

/* src/pwmcap_mdu.sv */
// Shared multiply/divide unit: shift-add multiply and restoring divide,
// one bit per cycle. Depends on pwmcap_pkg.
`default_nettype none
module pwmcap_mdu import pwmcap_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  mdu_cmd_t           cmd,
  input  logic [MDU_W-1:0]   opa,
  input  logic [MDU_B_W-1:0] opb,
  output mdu_sts_t           sts,
  output logic [MDU_W-1:0]   result
);

  logic [MDU_W-1:0]   acc_r, acc_nxt;
  logic [MDU_W-1:0]   opd_r, opd_nxt;
  logic [MDU_B_W-1:0] div_r, div_nxt;
  mdu_op_t            op_r;
  logic [STEP_W-1:0]  cnt_r;
  logic               busy_r;
  logic               done_r;

  logic [MDU_B_W:0]   rem_sh;
  logic [MDU_B_W:0]   diff;
  logic               ge;
  logic [MDU_W-1:0]   sum;

  assign rem_sh = {acc_r[MDU_B_W-1:0], opd_r[MDU_W-1]};
  assign ge     = rem_sh >= {1'b0, div_r};
  assign diff   = rem_sh - {1'b0, div_r};
  assign sum    = acc_r + opd_r;

  always_comb begin
    if (op_r == OP_MUL) begin
      acc_nxt = div_r[0] ? sum : acc_r;
      opd_nxt = {opd_r[MDU_W-2:0], 1'b0};
      div_nxt = {1'b0, div_r[MDU_B_W-1:1]};
    end else begin
      acc_nxt = {{(MDU_W-MDU_B_W-1){1'b0}}, ge ? diff : rem_sh};
      opd_nxt = {opd_r[MDU_W-2:0], ge};
      div_nxt = div_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= cmd.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r  <= cmd.op;
      acc_r <= '0;
      opd_r <= opa;
      div_r <= opb;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      opd_r <= opd_nxt;
      div_r <= div_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign result   = (op_r == OP_MUL) ? acc_r : opd_r;

endmodule
`default_nettype wire

/* src/pwm_pulse_capture_to_compare.sv */
// Top level of the PWM pulse capture to compare block: configuration registers,
// per-channel rising stamps, sequencer and result register.
// Depends on pwmcap_pkg, pwmcap_in_if, pwmcap_out_if and pwmcap_mdu.
//
// A rising edge stores its stamp for the channel and a capture on a channel of
// 3 or more is dropped; either leaves the sequencer idle. A falling edge produces one
// result: the width modulo 2^16, the compare value (width-min)*period/(max-min)
// clamped to max_compare, and the duty percent saturated at 100. Its work runs
// on a single multiply/divide unit that retires one bit per cycle: a 16-step
// multiply, a 32-step divide and a 23-step divide. A falling edge runs through
// S_PREP, S_MUL, S_DIV1, S_DIV2 and S_EMIT; an output_period of 0 skips the duty
// divide (S_DIV2), and S_PREP goes on to S_EMIT when the compare is zero by rule
// (max_pulse <= min_pulse or width <= min_pulse). A new capture is taken only
// while the sequencer is idle; a finished result waits in its own register, so
// the next capture can be taken before it is transferred.
`default_nettype none
module pwm_pulse_capture_to_compare import pwmcap_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  pwmcap_in_if.sink            in_ch,
  pwmcap_out_if.source         out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [REG_W-1:0]     cfg_wdata
);

  state_t state_r, state_nxt;

  logic [REG_W-1:0]   min_r, max_r, per_r, maxc_r;
  logic [TIMER_W-1:0] rise_r [CHANNELS];

  logic [CHAN_W-1:0]  chan_r;
  logic [TIMER_W-1:0] width_r;
  logic [REG_W-1:0]   cmp_r;
  logic [DUTY_W-1:0]  duty_r;

  logic               out_valid_r;
  logic [CHAN_W-1:0]  out_chan_r;
  logic [TIMER_W-1:0] out_width_r;
  logic [REG_W-1:0]   out_cmp_r;
  logic [DUTY_W-1:0]  out_duty_r;

  mdu_cmd_t           mdu_cmd;
  mdu_sts_t           mdu_sts;
  logic [MDU_W-1:0]   mdu_a;
  logic [MDU_B_W-1:0] mdu_b;
  logic [MDU_W-1:0]   mdu_res;

  logic                  in_xfer;
  logic                  chan_ok;
  logic                  zero_case;
  logic [REG_W-1:0]      cmp_c;
  logic [DUTY_DVD_W-1:0] cmp100;
  logic [DUTY_W-1:0]     duty_c;
  logic                  emit_go;

  pwmcap_mdu u_mdu (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (mdu_cmd),
    .opa    (mdu_a),
    .opb    (mdu_b),
    .sts    (mdu_sts),
    .result (mdu_res)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign chan_ok     = in_ch.chan < CHAN_W'(CHANNELS);
  assign zero_case   = (max_r <= min_r) || (width_r <= min_r);
  assign cmp_c       = (mdu_res > {{(MDU_W-REG_W){1'b0}}, maxc_r}) ? maxc_r
                                                                    : mdu_res[REG_W-1:0];
  assign cmp100      = {1'b0, cmp_c, 6'b0} + {2'b0, cmp_c, 5'b0} + {5'b0, cmp_c, 2'b0};
  assign duty_c      = (mdu_res[DUTY_DVD_W-1:0] > {{(DUTY_DVD_W-DUTY_W){1'b0}}, DUTY_FULL})
                       ? DUTY_FULL : mdu_res[DUTY_W-1:0];
  assign emit_go     = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    mdu_cmd   = '{start: 1'b0, op: OP_MUL, steps: MUL_STEPS};
    mdu_a     = '0;
    mdu_b     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && chan_ok && in_ch.falling) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if (zero_case) begin
          state_nxt = S_EMIT;
        end else begin
          mdu_cmd   = '{start: 1'b1, op: OP_MUL, steps: MUL_STEPS};
          mdu_a     = {{(MDU_W-TIMER_W){1'b0}}, width_r - min_r};
          mdu_b     = per_r;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (mdu_sts.done) begin
          mdu_cmd   = '{start: 1'b1, op: OP_DIV, steps: DIV_STEPS};
          mdu_a     = mdu_res;
          mdu_b     = max_r - min_r;
          state_nxt = S_DIV1;
        end
      end
      S_DIV1: begin
        if (mdu_sts.done) begin
          if (per_r == '0) begin
            state_nxt = S_EMIT;
          end else begin
            mdu_cmd   = '{start: 1'b1, op: OP_DIV, steps: DUTY_STEPS};
            mdu_a     = {cmp100, {(MDU_W-DUTY_DVD_W){1'b0}}};
            mdu_b     = per_r;
            state_nxt = S_DIV2;
          end
        end
      end
      S_DIV2: begin
        if (mdu_sts.done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= MIN_PULSE_RST;
      max_r  <= MAX_PULSE_RST;
      per_r  <= OUTPUT_PERIOD_RST;
      maxc_r <= MAX_COMPARE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MIN_PULSE:     min_r  <= cfg_wdata;
        REG_MAX_PULSE:     max_r  <= cfg_wdata;
        REG_OUTPUT_PERIOD: per_r  <= cfg_wdata;
        REG_MAX_COMPARE:   maxc_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        rise_r[i] <= '0;
      end
    end else if (in_xfer && chan_ok && !in_ch.falling) begin
      rise_r[in_ch.chan] <= in_ch.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && chan_ok && in_ch.falling) begin
      chan_r  <= in_ch.chan;
      width_r <= in_ch.stamp - rise_r[in_ch.chan];
    end
    if (state_r == S_PREP && zero_case) begin
      cmp_r  <= '0;
      duty_r <= '0;
    end
    if (state_r == S_DIV1 && mdu_sts.done) begin
      cmp_r  <= cmp_c;
      duty_r <= '0;
    end
    if (state_r == S_DIV2 && mdu_sts.done) begin
      duty_r <= duty_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_EMIT && emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && emit_go) begin
      out_chan_r  <= chan_r;
      out_width_r <= width_r;
      out_cmp_r   <= cmp_r;
      out_duty_r  <= duty_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_chan     = out_chan_r;
  assign out_ch.width        = out_width_r;
  assign out_ch.compare      = out_cmp_r;
  assign out_ch.duty_percent = out_duty_r;

  a_ready_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !mdu_sts.busy)
    else $error("capture taken while multiply/divide unit busy");

  a_done_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    mdu_sts.done |-> (state_r == S_MUL || state_r == S_DIV1 || state_r == S_DIV2))
    else $error("unit finished outside a working state");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.duty_percent <= DUTY_FULL)
    else $error("duty percent above full scale");

  a_cmp_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.compare <= maxc_r)
    else $error("compare value above clamp");

endmodule
`default_nettype wire

/* bench/pwm_pulse_capture_to_compare_tb.sv */
// Self-checking bench for pwm_pulse_capture_to_compare: queued edge captures driven over
// several register settings, each result checked against an in-bench pulse-width predictor.
// Depends on pwmcap_pkg, pwmcap_in_if, pwmcap_out_if and the block itself.
`default_nettype none
module pwm_pulse_capture_to_compare_tb;
  import pwmcap_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 10;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [CHAN_W-1:0]  chan;
    logic               falling;
    logic [TIMER_W-1:0] stamp;
  } capture_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  chan;
    logic [TIMER_W-1:0] width;
    logic [REG_W-1:0]   compare;
    logic [DUTY_W-1:0]  duty;
  } pulse_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [REG_W-1:0] cfg_wdata;

  pwmcap_in_if  in_ch();
  pwmcap_out_if out_ch();

  pwm_pulse_capture_to_compare u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  capture_t capture_q[$];
  pulse_t   pulse_q[$];

  logic [TIMER_W-1:0] rise_ts [CHANNELS];
  logic [REG_W-1:0] reg_min, reg_max, reg_period, reg_maxc;

  int err_cnt, n_rise, n_fall, n_skip, n_pulses, n_settings;
  int in_xfers, launch_mark, quiet_cycles;
  int in_gap, out_gap, in_idle_pct, out_idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic bit predict_pulse(input capture_t c, output pulse_t p);
    logic [TIMER_W-1:0] w;
    logic [63:0] cmp;
    logic [63:0] duty;
    p = '0;
    if (c.chan >= CHANNELS) return 1'b0;
    if (!c.falling) begin
      rise_ts[c.chan] = c.stamp;
      return 1'b0;
    end
    w = c.stamp - rise_ts[c.chan];
    if (reg_max <= reg_min || w <= reg_min) begin
      cmp = '0;
    end else begin
      cmp = (64'(w - reg_min) * 64'(reg_period)) / 64'(reg_max - reg_min);
      if (cmp > 64'(reg_maxc)) cmp = 64'(reg_maxc);
    end
    if (reg_period == '0) begin
      duty = '0;
    end else begin
      duty = (cmp * 64'(DUTY_FULL)) / 64'(reg_period);
      if (duty > 64'(DUTY_FULL)) duty = 64'(DUTY_FULL);
    end
    p.chan = c.chan;
    p.width = w;
    p.compare = cmp[REG_W-1:0];
    p.duty = duty[DUTY_W-1:0];
    return 1'b1;
  endfunction

  // capture driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!(in_ch.valid && in_xfers == launch_mark)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if ($urandom_range(0, 99) < in_idle_pct) begin
        in_gap = $urandom_range(1, 19) - 1;
        in_ch.valid <= 1'b0;
      end else if (capture_q.size() > 0) begin
        in_ch.chan <= capture_q[0].chan;
        in_ch.falling <= capture_q[0].falling;
        in_ch.stamp <= capture_q[0].stamp;
        in_ch.valid <= 1'b1;
        launch_mark = in_xfers;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result sink
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < out_idle_pct) begin
      out_gap = $urandom_range(1, 19) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    capture_t c;
    pulse_t p;
    pulse_t e;
    if (rst_n) begin
      quiet_cycles++;
      if (out_ch.valid && out_ch.ready) begin
        quiet_cycles = 0;
        n_pulses++;
        p.chan = out_ch.out_chan;
        p.width = out_ch.width;
        p.compare = out_ch.compare;
        p.duty = out_ch.duty_percent;
        if (pulse_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result chan %0d width %0d", p.chan, p.width));
        end else begin
          e = pulse_q.pop_front();
          if (p.chan != e.chan)
            report_mismatch($sformatf("out_chan %0d, want %0d", p.chan, e.chan));
          if (p.width != e.width)
            report_mismatch($sformatf("width %0d, want %0d", p.width, e.width));
          if (p.compare != e.compare)
            report_mismatch($sformatf("compare %0d, want %0d (width %0d)",
                                      p.compare, e.compare, e.width));
          if (p.duty != e.duty)
            report_mismatch($sformatf("duty_percent %0d, want %0d (compare %0d)",
                                      p.duty, e.duty, e.compare));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        quiet_cycles = 0;
        in_xfers++;
        void'(capture_q.pop_front());
        c.chan = in_ch.chan;
        c.falling = in_ch.falling;
        c.stamp = in_ch.stamp;
        if (c.chan >= CHANNELS) n_skip++;
        else if (c.falling) n_fall++;
        else n_rise++;
        if (predict_pulse(c, e)) pulse_q.push_back(e);
      end
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  task automatic push_edge(input logic [CHAN_W-1:0] ch, input logic fall,
                           input logic [TIMER_W-1:0] stamp);
    capture_t c;
    c.chan = ch;
    c.falling = fall;
    c.stamp = stamp;
    capture_q.push_back(c);
  endtask

  task automatic wait_idle();
    while (capture_q.size() > 0 || pulse_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_regs(input logic [REG_W-1:0] mn, input logic [REG_W-1:0] mx,
                          input logic [REG_W-1:0] per, input logic [REG_W-1:0] mc);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [REG_W-1:0] val [4];
    idx = '{REG_MIN_PULSE, REG_MAX_PULSE, REG_OUTPUT_PERIOD, REG_MAX_COMPARE};
    val = '{mn, mx, per, mc};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we = 1'b1;
      cfg_idx = idx[i];
      cfg_wdata = val[i];
    end
    @(negedge clk);
    cfg_we = 1'b0;
    reg_min = mn;
    reg_max = mx;
    reg_period = per;
    reg_maxc = mc;
    n_settings++;
  endtask

  task automatic queue_random(input int n);
    int made;
    int r;
    logic [CHAN_W-1:0] ch;
    logic [TIMER_W-1:0] rise;
    logic [TIMER_W-1:0] w;
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      ch = CHAN_W'($urandom_range(0, CHANNELS - 1));
      rise = TIMER_W'($urandom);
      if (r < 78) begin
        case ($urandom_range(0, 3))
          0: w = TIMER_W'($urandom);
          1: w = (reg_max > reg_min) ?
                 reg_min + TIMER_W'($urandom_range(0, reg_max - reg_min)) : TIMER_W'($urandom);
          2: w = ($urandom_range(0, 1) ? reg_min : reg_max) + TIMER_W'($urandom_range(0, 4))
                 - TIMER_W'(2);
          default: w = TIMER_W'($urandom_range(0, 255));
        endcase
        push_edge(ch, 1'b0, rise);
        push_edge(ch, 1'b1, rise + w);
        made += 2;
      end else if (r < 88) begin
        push_edge(ch, 1'b1, TIMER_W'($urandom));
        made++;
      end else if (r < 95) begin
        push_edge(ch, 1'b0, rise);
        made++;
      end else begin
        push_edge(CHAN_W'(CHANNELS), 1'($urandom_range(0, 1)), TIMER_W'($urandom));
        made++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_MIN_PULSE;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.chan = '0;
    in_ch.falling = 1'b0;
    in_ch.stamp = '0;
    out_ch.ready = 1'b0;
    reg_min = MIN_PULSE_RST;
    reg_max = MAX_PULSE_RST;
    reg_period = OUTPUT_PERIOD_RST;
    reg_maxc = MAX_COMPARE_RST;
    for (int i = 0; i < CHANNELS; i++) rise_ts[i] = '0;
    in_gap = 0;
    out_gap = 0;
    in_idle_pct = 15;
    out_idle_pct = 15;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: falling edges with no prior rise, wrap, boundaries, unused channel
    push_edge(2'd0, 1'b1, 16'd1500);
    push_edge(2'd1, 1'b1, 16'hFFFF);
    push_edge(2'd0, 1'b0, 16'd0);
    push_edge(2'd0, 1'b1, 16'hFFFF);
    push_edge(2'd1, 1'b0, 16'd65000);
    push_edge(2'd1, 1'b1, 16'd500);
    push_edge(2'd2, 1'b0, 16'd100);
    push_edge(2'd2, 1'b1, 16'd1100);
    push_edge(2'd2, 1'b1, 16'd1101);
    push_edge(2'd2, 1'b1, 16'd2100);
    push_edge(2'd2, 1'b1, 16'd1600);
    push_edge(CHAN_W'(CHANNELS), 1'b0, 16'h5555);
    push_edge(CHAN_W'(CHANNELS), 1'b1, 16'hAAAA);
    push_edge(2'd2, 1'b1, 16'd100);
    queue_random(120);
    wait_idle();

    set_regs(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_edge(2'd0, 1'b0, 16'd0);
    push_edge(2'd0, 1'b1, 16'hFFFF);
    push_edge(2'd1, 1'b0, 16'h1234);
    push_edge(2'd1, 1'b1, 16'h1234);
    queue_random(120);
    wait_idle();

    in_idle_pct = 40;
    out_idle_pct = 5;
    set_regs(16'd5000, 16'd5000, 16'd1000, 16'd1000);
    queue_random(110);
    wait_idle();

    in_idle_pct = 5;
    out_idle_pct = 40;
    set_regs(16'hFFFF, 16'd0, 16'd1, 16'hFFFF);
    queue_random(110);
    wait_idle();

    set_regs(16'd100, 16'd300, 16'd0, 16'hFFFF);
    queue_random(110);
    wait_idle();

    in_idle_pct = 15;
    out_idle_pct = 15;
    set_regs(16'd1000, 16'd1001, 16'hFFFF, 16'd40000);
    queue_random(110);
    wait_idle();

    set_regs(16'd0, 16'd1, 16'd1, 16'd0);
    queue_random(100);
    wait_idle();

    for (int k = 0; k < 3; k++) begin
      in_idle_pct = $urandom_range(0, 30);
      out_idle_pct = $urandom_range(0, 30);
      set_regs(16'($urandom_range(0, 4000)), 16'($urandom_range(0, 12000)),
               16'($urandom_range(1, 65535)), 16'($urandom));
      queue_random(80);
      wait_idle();
    end

    // no idling on either side to the end
    in_idle_pct = 0;
    out_idle_pct = 0;
    set_regs(16'd1000, 16'd2000, 16'd1000, 16'd1000);
    queue_random(110);

    while (capture_q.size() > 0 || pulse_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pulse_q.size() > 0)
      report_mismatch($sformatf("%0d results never arrived", pulse_q.size()));

    $display("Covered %0d rising, %0d falling and %0d unused-channel captures", n_rise,
             n_fall, n_skip);
    $display("over %0d register settings; %0d results checked, %0d mismatches", n_settings,
             n_pulses, err_cnt);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
src/pwmcap_pkg.sv
src/pwmcap_in_if.sv
src/pwmcap_out_if.sv
src/pwmcap_mdu.sv
src/pwm_pulse_capture_to_compare.sv
bench/pwm_pulse_capture_to_compare_tb.sv
